// File: rtl/core/json_string_escaper_assert.svh
// Assertion macros shared by the escaper RTL.
// Each macro checks a property on the rising clock edge, outside reset.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define JSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define JSE_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [15:0] BUF_SIZE_RST    = 16'd256;

  // Register indexes on the configuration port (word address bit 2).
  localparam logic REG_IDX_BUFFER_SIZE = 1'b0;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  typedef enum logic [1:0] {
    JOB_PLAIN,
    JOB_SHORT,
    JOB_UNI,
    JOB_END
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  // Letter that follows the backslash, zero when the byte has no short escape.
  function automatic logic [7:0] short_letter(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h22:   r = CH_QUOTE;
      8'h5C:   r = CH_BSLASH;
      8'h08:   r = 8'h62;
      8'h0A:   r = 8'h6E;
      8'h0D:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'b0000, v};
    end else begin
      r = 8'h57 + {4'b0000, v};
    end
    return r;
  endfunction

  function automatic logic [2:0] job_len(input job_kind_t k);
    logic [2:0] r;
    case (k)
      JOB_SHORT: r = 3'd2;
      JOB_UNI:   r = 3'd6;
      default:   r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/json_string_escaper.sv
// JSON string escaper. Feed string bytes one per transfer on byte_value;
// escaped bytes come out one per transfer on out_byte, with last_of_run
// marking the final byte produced by each input byte. A zero input byte
// ends the string: it always yields a single zero byte with last_of_run
// set and restores the budget to buffer_size - 1 (zero when buffer_size
// is zero). Quote, backslash, backspace, newline, carriage return and tab
// become a two-byte escape, other control bytes the six-byte \u00xx form,
// everything else passes through. A byte whose escape does not fit the
// remaining budget yields nothing and silences the rest of the string.
// Rate: the back end emits one byte per cycle, unless out_ready stalls
// it, from the head of a QUEUE_DEPTH-entry job queue; the front end keeps
// taking input at one byte per cycle until that queue fills. An item's
// first output byte passes through the job queue and then the back end's
// output register before it is presented. buffer_size sits at byte
// address 0 of the APB port; write it only while the block is idle.
`timescale 1ns / 1ps

`include "json_string_escaper_assert.svh"

module json_string_escaper #(
  parameter int unsigned QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input string bytes
  input  logic [7:0]  byte_value,
  input  logic        in_valid,
  output logic        in_ready,
  // escaped output bytes
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        out_valid,
  input  logic        out_ready
);
  import jse_pkg::*;

  logic [15:0] buffer_size;
  logic        cfg_write;
  logic        queue_full;
  logic        queue_empty;
  logic        job_push;
  logic        job_pop;
  job_t        job_in;
  job_t        job_head;

  // Register file: a single word, buffer_size, in the low half.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RST;
    end else if (cfg_write && (paddr[2] == REG_IDX_BUFFER_SIZE)) begin
      buffer_size <= pwdata[15:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    if (paddr[2] == REG_IDX_BUFFER_SIZE) begin
      prdata = {16'd0, buffer_size};
    end else begin
      prdata = '0;
    end
  end

  // Front end: classify each byte, charge the budget, drop silenced bytes.
  jse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_value  (byte_value),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .buffer_size (buffer_size),
    .queue_full  (queue_full),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Queue between the sides so that a long escape does not hold the input.
  jse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (queue_full),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (queue_empty)
  );

  // Back end: expand each job into its escape bytes, one per cycle unless out_ready stalls it.
  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (job_head),
    .empty       (queue_empty),
    .pop         (job_pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // A zero byte leaves only as a string terminator, which is always last.
  `JSE_ASSERT_NOW(a_zero_is_last, clk, rst, out_valid && (out_byte == 8'h00), last_of_run, "zero byte not marked last")

endmodule

// File: rtl/core/jse_front.sv
`timescale 1ns / 1ps

module jse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_value,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   buffer_size,
  input  logic          queue_full,
  output logic          job_push,
  output jse_pkg::job_t job
);
  import jse_pkg::*;

  logic [15:0] remaining_room;
  logic [15:0] remaining_room_next;
  logic        output_stopped;
  logic        output_stopped_next;
  logic        accept;
  logic        is_end;
  logic [7:0]  letter;
  logic [2:0]  len;
  logic        fits;
  logic [15:0] fresh;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_end   = (byte_value == 8'h00);
  assign letter   = short_letter(byte_value);
  assign fresh    = (buffer_size == 16'd0) ? 16'd0 : buffer_size - 16'd1;

  always_comb begin
    if (is_end) begin
      job.kind = JOB_END;
      job.data = byte_value;
    end else if (letter != 8'h00) begin
      job.kind = JOB_SHORT;
      job.data = letter;
    end else if (byte_value < CTRL_TOP) begin
      job.kind = JOB_UNI;
      job.data = byte_value;
    end else begin
      job.kind = JOB_PLAIN;
      job.data = byte_value;
    end
  end

  assign len      = job_len(job.kind);
  assign fits     = remaining_room >= {13'd0, len};
  assign job_push = accept && (is_end || (!output_stopped && fits));

  always_comb begin
    remaining_room_next = remaining_room;
    output_stopped_next = output_stopped;
    if (accept) begin
      if (is_end) begin
        remaining_room_next = fresh;
        output_stopped_next = 1'b0;
      end else if (!output_stopped) begin
        if (fits) begin
          remaining_room_next = remaining_room - {13'd0, len};
        end else begin
          output_stopped_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_room <= BUF_SIZE_RST - 16'd1;
      output_stopped <= 1'b0;
    end else begin
      remaining_room <= remaining_room_next;
      output_stopped <= output_stopped_next;
    end
  end

endmodule

// File: rtl/core/jse_fifo.sv
`timescale 1ns / 1ps

`include "json_string_escaper_assert.svh"

// Job queue; DEPTH must be a power of two, at least two.
module jse_fifo #(
  parameter int unsigned DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output jse_pkg::job_t dout,
  output logic          empty
);
  import jse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `JSE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overflow")
  `JSE_ASSERT_NEXT(a_count_grow, clk, rst, do_push && !do_pop, count == $past(count) + CW'(1), "queue count did not grow")

endmodule

// File: rtl/core/jse_back.sv
`timescale 1ns / 1ps

module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  jse_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic          out_valid,
  input  logic          out_ready
);
  import jse_pkg::*;

  logic [2:0] idx;
  logic [2:0] len;
  logic       load;
  logic       is_last;
  logic [7:0] cur;

  assign len     = job_len(head.kind);
  assign load    = !empty && (!out_valid || out_ready);
  assign is_last = (idx == len - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    case (head.kind)
      JOB_SHORT: begin
        cur = (idx == 3'd0) ? CH_BSLASH : head.data;
      end
      JOB_UNI: begin
        case (idx)
          3'd0:    cur = CH_BSLASH;
          3'd1:    cur = CH_U;
          3'd4:    cur = hex_digit(head.data[7:4]);
          3'd5:    cur = hex_digit(head.data[3:0]);
          default: cur = CH_ZERO;
        endcase
      end
      default: begin
        cur = head.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= cur;
      last_of_run <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sim/escape_checker.sv
`timescale 1ns / 1ps

module escape_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic [7:0]  byte_value,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_of_run,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          mismatches,
  output int          pending,
  output int          bytes_in,
  output int          bytes_out,
  output int          strings_done,
  output int          overflows
);
  import jse_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } escaped_byte_t;

  localparam logic [7:0] ASCII_BS  = 8'h08;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_LF  = 8'h0A;
  localparam logic [7:0] ASCII_CR  = 8'h0D;
  localparam logic [7:0] ASCII_NUL = 8'h00;
  localparam logic [127:0] HEX_CHARS = "0123456789abcdef";

  logic [15:0]   buffer_size_q;
  logic [15:0]   room_q;
  logic          stopped_q;
  escaped_byte_t escaped_q [$];

  function automatic logic [15:0] budget_of(input logic [15:0] size);
    return (size == 16'd0) ? 16'd0 : size - 16'd1;
  endfunction

  // Work out the escaped bytes one accepted string byte should produce.
  task automatic predict_escape(input logic [7:0] b);
    logic [7:0]    seq [0:5];
    logic [7:0]    letter;
    int unsigned   n;
    escaped_byte_t entry;
    letter = ASCII_NUL;
    seq[0] = b;
    n = 1;
    if (b == ASCII_NUL) begin
      entry.ch = ASCII_NUL;
      entry.last = 1'b1;
      escaped_q.push_back(entry);
      room_q = budget_of(buffer_size_q);
      stopped_q = 1'b0;
      strings_done++;
    end else if (!stopped_q) begin
      case (b)
        CH_QUOTE:  letter = CH_QUOTE;
        CH_BSLASH: letter = CH_BSLASH;
        ASCII_BS:  letter = "b";
        ASCII_LF:  letter = "n";
        ASCII_CR:  letter = "r";
        ASCII_TAB: letter = "t";
        default:   letter = ASCII_NUL;
      endcase
      if (letter != ASCII_NUL) begin
        seq[0] = CH_BSLASH;
        seq[1] = letter;
        n = 2;
      end else if (b < CTRL_TOP) begin
        seq[0] = CH_BSLASH;
        seq[1] = CH_U;
        seq[2] = CH_ZERO;
        seq[3] = CH_ZERO;
        seq[4] = HEX_CHARS[8 * (15 - b[7:4]) +: 8];
        seq[5] = HEX_CHARS[8 * (15 - b[3:0]) +: 8];
        n = 6;
      end
      // the whole sequence or nothing; a miss silences the rest of the string
      if (room_q < n) begin
        stopped_q = 1'b1;
        overflows++;
      end else begin
        room_q = room_q - 16'(n);
        for (int unsigned k = 0; k < n; k++) begin
          entry.ch = seq[k];
          entry.last = (k + 1 == n);
          escaped_q.push_back(entry);
        end
      end
    end
  endtask

  task automatic check_output();
    escaped_byte_t want;
    if (escaped_q.size() == 0) begin
      $error("unexpected output: out_byte 8'h%02h last_of_run %0b", out_byte, last_of_run);
      mismatches++;
    end else begin
      want = escaped_q.pop_front();
      if (out_byte !== want.ch) begin
        $error("out_byte: expected 8'h%02h, actual 8'h%02h", want.ch, out_byte);
        mismatches++;
      end
      if (last_of_run !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
        mismatches++;
      end
    end
    bytes_out++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      buffer_size_q = BUF_SIZE_RST;
      room_q = budget_of(BUF_SIZE_RST);
      stopped_q = 1'b0;
      escaped_q.delete();
      mismatches = 0;
      bytes_in = 0;
      bytes_out = 0;
      strings_done = 0;
      overflows = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_BUFFER_SIZE) begin
        buffer_size_q = pwdata[15:0];
      end
      // older results first, so an early result cannot hide behind a new entry
      if (out_valid && out_ready) begin
        check_output();
      end
      if (in_valid && in_ready) begin
        predict_escape(byte_value);
        bytes_in++;
      end
    end
    pending = escaped_q.size();
  end

endmodule

// File: sim/tb_json_string_escaper.sv
`timescale 1ns / 1ps

module tb_json_string_escaper;
  import jse_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  // Length of the deliberate output stall that backs the block up.
  localparam int LONG_HOLD   = 150;
  // Margin after the last result, well past the job queue and output register.
  localparam int SETTLE_GAP  = 8;

  logic        clk;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [7:0]  byte_value = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        out_valid;
  logic        out_ready  = 1'b0;

  int mismatches;
  int pending;
  int bytes_in;
  int bytes_out;
  int strings_done;
  int overflows;

  // Idle percentages for each side, changed only between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus bumps hold_asked; the receiver serves it with one long stall.
  int hold_asked  = 0;
  int hold_given  = 0;
  int hold_left   = 0;
  int quiet_count = 0;

  // Opening string: pass-through extremes, every short escape, a spread of
  // control bytes for the \u00xx form, then the terminator.
  logic [7:0] opening [15] = '{8'h41, 8'h20, 8'hFF, 8'h80, 8'h7F, CH_QUOTE, CH_BSLASH,
                               8'h08, 8'h0A, 8'h0D, 8'h09, 8'h01, 8'h1F, 8'h1A, 8'h00};

  json_string_escaper dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .byte_value  (byte_value),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  escape_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .byte_value   (byte_value),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mismatches   (mismatches),
    .pending      (pending),
    .bytes_in     (bytes_in),
    .bytes_out    (bytes_out),
    .strings_done (strings_done),
    .overflows    (overflows)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold when the stimulus asks.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_asked != hold_given) begin
      hold_given = hold_asked;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: drop the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("tb_json_string_escaper: errors");
        $finish;
      end
    end
  end

  // Offer one string byte and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering, wait for every outstanding result, then allow for
  // silenced bytes still in the pipeline before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Two-phase register write; the upper data bits are junk and must be dropped.
  task automatic write_buffer_size(input logic [15:0] size);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_IDX_BUFFER_SIZE, 2'b00};
    pwdata <= {junk, size};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Well-formed strings with random text: mostly plain bytes, a fair share
  // of short and \u escapes, and now and then no terminator so that two
  // strings run together.
  task automatic send_strings(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(0, 10);
      for (int unsigned k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            case ($urandom_range(0, 5))
              0:       b = CH_QUOTE;
              1:       b = CH_BSLASH;
              2:       b = 8'h08;
              3:       b = 8'h0A;
              4:       b = 8'h0D;
              default: b = 8'h09;
            endcase
          end
          2, 3:    b = 8'($urandom_range(1, 31));
          4:       b = 8'($urandom_range(1, 255));
          default: b = 8'($urandom_range(32, 255));
        endcase
        send_byte(b);
        sent++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_byte(8'h00);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] size;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset budget of 255, every kind of byte once.
    foreach (opening[i]) begin
      send_byte(opening[i]);
    end

    // Size seven: this string still runs on the budget of 255 set by the reset
    // size, so every byte gets through; the terminator loads a budget of six.
    settle();
    write_buffer_size(16'd7);
    send_byte(8'h1B);
    send_byte(8'h78);
    send_byte(8'h0A);
    send_byte(8'h00);

    // Budget of six, size rewritten to three and then to zero mid-string: the
    // old budget holds until the terminator, so 'a', 'b' and 'c' all fit.
    settle();
    write_buffer_size(16'd3);
    send_byte(8'h61);
    settle();
    write_buffer_size(16'd0);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h00);
    // Zero size: nothing but the terminator gets through.
    send_byte(8'h65);
    send_byte(8'h00);

    // Random: three idling mixes, each across a tight, a middling and an
    // extreme (or, in the last mix, random) buffer size.
    for (int ph = 0; ph < 3; ph++) begin
      for (int sub = 0; sub < 3; sub++) begin
        settle();
        case (ph)
          0: begin
            send_idle_pct = 20;
            recv_idle_pct = 84;
          end
          1: begin
            send_idle_pct = 84;
            recv_idle_pct = 20;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        case (sub)
          0:       size = 16'($urandom_range(1, 16));
          1:       size = 16'($urandom_range(17, 300));
          default: size = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd1 :
                          16'($urandom_range(0, 65535));
        endcase
        write_buffer_size(size);
        // Back the block up once with the sender running flat out.
        if (ph == 2 && sub == 1) begin
          hold_asked++;
        end
        send_strings((size == 16'd1) ? 8 : 48);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d string bytes in, %0d escaped bytes out, %0d strings, %0d cut short",
             bytes_in, bytes_out, strings_done, overflows);
    $display("buffer sizes from 0 to 65535, three idle mixes and one long output stall");
    if (mismatches == 0) begin
      $display("tb_json_string_escaper: clean");
    end else begin
      $display("tb_json_string_escaper: errors");
    end
    $finish;
  end

endmodule
